// ===== src/tensor_header_parser_defines.svh =====
// Assertion macros shared by the tensor header parser modules.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef TENSOR_HEADER_PARSER_DEFINES_SVH
`define TENSOR_HEADER_PARSER_DEFINES_SVH

`define THP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`define THP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/thp_pkg.sv =====
`timescale 1ns / 1ps

package thp_pkg;

  localparam int InLenW        = 32;
  localparam int OffsetW       = 11;
  localparam int DefLengthBits = 32;
  localparam int DefFifoDepth  = 2;

  localparam int MagicBytes     = 8;
  localparam int DimBytes       = 4;
  localparam int FixedPartBytes = 16;
  localparam int SizesBytes     = 16;
  localparam int MinLength      = 12;

  localparam logic [OffsetW-1:0] DefMinHeaderSize = 11'd32;

  typedef enum logic [1:0] {
    CFG_MAGIC    = 2'd0,
    CFG_VERSION  = 2'd1,
    CFG_MIN_SIZE = 2'd2
  } thp_cfg_e;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_DIM   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } thp_kind_e;

  typedef enum logic [2:0] {
    ERR_TOO_SMALL = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_VERSION   = 3'd2,
    ERR_FIELDS    = 3'd3,
    ERR_NAME      = 3'd4,
    ERR_SHAPE     = 3'd5,
    ERR_SIZES     = 3'd6
  } thp_err_e;

  typedef struct packed {
    logic [7:0]        byte_value;
    logic [InLenW-1:0] buffer_length;
    logic              first_byte;
  } thp_in_t;

  typedef struct packed {
    thp_kind_e          kind;
    logic [63:0]        value;
    logic [63:0]        stored_size;
    logic [7:0]         dtype_code;
    logic [7:0]         compression_code;
    logic [7:0]         dim_count;
    logic [7:0]         name_length;
    logic [OffsetW-1:0] payload_offset;
    thp_err_e           error_code;
    logic               last;
  } thp_out_t;

endpackage

// ===== src/thp_front.sv =====
`timescale 1ns / 1ps

module thp_front #(
  parameter int LENGTH_BITS = thp_pkg::DefLengthBits
) (
  input  thp_pkg::thp_in_t                         in_word_i,
  input  logic [thp_pkg::OffsetW-1:0]              min_size_i,
  output logic [((LENGTH_BITS < thp_pkg::InLenW) ?
                 LENGTH_BITS : thp_pkg::InLenW)+9:0] entry_o
);

  localparam int LenW = (LENGTH_BITS < thp_pkg::InLenW) ? LENGTH_BITS : thp_pkg::InLenW;
  localparam logic [thp_pkg::InLenW:0] MaxLen = ((thp_pkg::InLenW+1)'(1) << LenW)
                                                - (thp_pkg::InLenW+1)'(1);

  logic [LenW-1:0] len_sat;
  logic            too_small;

  // The length is clipped to the counter width before the size checks.
  assign len_sat = ({1'b0, in_word_i.buffer_length} > MaxLen) ?
                   MaxLen[LenW-1:0] : in_word_i.buffer_length[LenW-1:0];

  assign too_small = (len_sat < {{(LenW-thp_pkg::OffsetW){1'b0}}, min_size_i}) ||
                     (len_sat < LenW'(thp_pkg::MinLength));

  assign entry_o = {len_sat, too_small, in_word_i.first_byte, in_word_i.byte_value};

endmodule

// ===== src/thp_fifo.sv =====
`timescale 1ns / 1ps
`include "tensor_header_parser_defines.svh"

module thp_fifo #(
  parameter int WIDTH = 42,
  parameter int DEPTH = thp_pkg::DefFifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH-1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH-1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `THP_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "queue count exceeds depth")

endmodule

// ===== src/thp_back.sv =====
`timescale 1ns / 1ps
`include "tensor_header_parser_defines.svh"

module thp_back #(
  parameter int LENGTH_BITS = thp_pkg::DefLengthBits
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [63:0]                               magic_i,
  input  logic [31:0]                               version_i,
  input  logic                                      entry_valid_i,
  input  logic [((LENGTH_BITS < thp_pkg::InLenW) ?
                 LENGTH_BITS : thp_pkg::InLenW)+9:0] entry_i,
  output logic                                      pop_o,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output thp_pkg::thp_out_t                         out_word_o
);

  localparam int LenW = (LENGTH_BITS < thp_pkg::InLenW) ? LENGTH_BITS : thp_pkg::InLenW;
  localparam int OffW = thp_pkg::OffsetW;

  typedef enum logic [3:0] {
    PH_IDLE, PH_MAGIC, PH_VERSION, PH_FIELDS, PH_NAME, PH_SHAPE, PH_SIZE_A, PH_SIZE_B
  } phase_e;

  phase_e            phase_q, phase_d, ph_eff;
  logic [OffW-1:0]   pos_q, pos_d, pos_eff, pos_new;
  logic [2:0]        fbc_q, fbc_d, fbc_eff;
  logic [LenW-1:0]   len_q, len_d, len_eff;
  logic [63:0]       asm_q, asm_d, asm_eff, asm_new;
  logic [63:0]       orig_q, orig_d;
  logic [7:0]        dtype_q, dtype_d;
  logic [7:0]        comp_q, comp_d;
  logic [7:0]        dc_q, dc_d;
  logic [7:0]        nl_q, nl_d;
  logic [7:0]        items_q, items_d, items_eff, items_dec;
  logic              out_valid_q, out_valid_d;
  thp_pkg::thp_out_t out_q, out_d, res;
  logic              res_valid;

  logic [7:0]        e_byte;
  logic              e_first, e_small;
  logic [LenW-1:0]   e_len;
  logic [OffW-1:0]   need_name, need_shape, need_sizes;

  assign e_byte  = entry_i[7:0];
  assign e_first = entry_i[8];
  assign e_small = entry_i[9];
  assign e_len   = entry_i[LenW+9:10];

  assign pop_o       = entry_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // A first byte restarts the header: the magic field is entered at once.
  assign ph_eff    = e_first ? PH_MAGIC : phase_q;
  assign fbc_eff   = e_first ? 3'd0 : fbc_q;
  assign asm_eff   = e_first ? 64'd0 : asm_q;
  assign pos_eff   = e_first ? '0 : pos_q;
  assign len_eff   = e_first ? e_len : len_q;
  assign items_eff = e_first ? 8'd0 : items_q;
  assign pos_new   = pos_eff + OffW'(1);
  assign items_dec = items_eff - 8'd1;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      asm_new[8*k +: 8] = asm_eff[8*k +: 8] | ((fbc_eff == 3'(k)) ? e_byte : 8'd0);
    end
  end

  assign need_name  = OffW'(thp_pkg::FixedPartBytes) + OffW'(e_byte);
  assign need_shape = need_name + OffW'({dc_q, 2'b00});
  assign need_sizes = need_shape + OffW'(thp_pkg::SizesBytes);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    fbc_d       = fbc_q;
    len_d       = len_q;
    asm_d       = asm_q;
    orig_d      = orig_q;
    dtype_d     = dtype_q;
    comp_d      = comp_q;
    dc_d        = dc_q;
    nl_d        = nl_q;
    items_d     = items_q;
    res         = '0;
    res_valid   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (pop_o) begin
      if (e_first) begin
        len_d   = e_len;
        pos_d   = '0;
        items_d = 8'd0;
      end
      if (e_first && e_small) begin
        phase_d        = PH_IDLE;
        res_valid      = 1'b1;
        res.kind       = thp_pkg::KIND_ERROR;
        res.error_code = thp_pkg::ERR_TOO_SMALL;
        res.last       = 1'b1;
      end else if (ph_eff != PH_IDLE) begin
        phase_d = ph_eff;
        pos_d   = pos_new;
        fbc_d   = fbc_eff + 3'd1;
        asm_d   = asm_new;
        case (ph_eff)
          PH_MAGIC: begin
            if (fbc_eff == 3'(thp_pkg::MagicBytes - 1)) begin
              fbc_d = 3'd0;
              asm_d = 64'd0;
              if (asm_new != magic_i) begin
                phase_d        = PH_IDLE;
                res_valid      = 1'b1;
                res.kind       = thp_pkg::KIND_ERROR;
                res.error_code = thp_pkg::ERR_MAGIC;
                res.last       = 1'b1;
              end else begin
                phase_d = PH_VERSION;
              end
            end
          end
          PH_VERSION: begin
            if (fbc_eff == 3'(thp_pkg::DimBytes - 1)) begin
              fbc_d = 3'd0;
              asm_d = 64'd0;
              if (asm_new != {32'd0, version_i}) begin
                phase_d        = PH_IDLE;
                res_valid      = 1'b1;
                res.kind       = thp_pkg::KIND_ERROR;
                res.error_code = thp_pkg::ERR_VERSION;
                res.last       = 1'b1;
              end else if (len_eff < LenW'(thp_pkg::FixedPartBytes)) begin
                phase_d        = PH_IDLE;
                res_valid      = 1'b1;
                res.kind       = thp_pkg::KIND_ERROR;
                res.error_code = thp_pkg::ERR_FIELDS;
                res.last       = 1'b1;
              end else begin
                phase_d = PH_FIELDS;
              end
            end
          end
          PH_FIELDS: begin
            asm_d = asm_eff;
            case (fbc_eff)
              3'd0: dtype_d = e_byte;
              3'd1: comp_d  = e_byte;
              3'd2: dc_d    = e_byte;
              default: begin
                nl_d = e_byte;
                res.kind       = thp_pkg::KIND_ERROR;
                res.last       = 1'b1;
                if (LenW'(need_name) > len_eff) begin
                  phase_d        = PH_IDLE;
                  res_valid      = 1'b1;
                  res.error_code = thp_pkg::ERR_NAME;
                end else if (LenW'(need_shape) > len_eff) begin
                  phase_d        = PH_IDLE;
                  res_valid      = 1'b1;
                  res.error_code = thp_pkg::ERR_SHAPE;
                end else if (LenW'(need_sizes) > len_eff) begin
                  phase_d        = PH_IDLE;
                  res_valid      = 1'b1;
                  res.error_code = thp_pkg::ERR_SIZES;
                end else if (e_byte != 8'd0) begin
                  phase_d = PH_NAME;
                  fbc_d   = fbc_eff;
                  items_d = e_byte;
                end else if (dc_q != 8'd0) begin
                  phase_d = PH_SHAPE;
                  fbc_d   = 3'd0;
                  asm_d   = 64'd0;
                  items_d = dc_q;
                end else begin
                  phase_d = PH_SIZE_A;
                  fbc_d   = 3'd0;
                  asm_d   = 64'd0;
                end
                if (!res_valid) begin
                  res = '0;
                end
              end
            endcase
          end
          PH_NAME: begin
            fbc_d     = fbc_eff;
            asm_d     = asm_eff;
            items_d   = items_dec;
            res_valid = 1'b1;
            res.kind  = thp_pkg::KIND_NAME;
            res.value = {56'd0, e_byte};
            if (items_dec == 8'd0) begin
              fbc_d = 3'd0;
              asm_d = 64'd0;
              if (dc_q != 8'd0) begin
                phase_d = PH_SHAPE;
                items_d = dc_q;
              end else begin
                phase_d = PH_SIZE_A;
              end
            end
          end
          PH_SHAPE: begin
            if (fbc_eff == 3'(thp_pkg::DimBytes - 1)) begin
              fbc_d     = 3'd0;
              asm_d     = 64'd0;
              items_d   = items_dec;
              phase_d   = (items_dec == 8'd0) ? PH_SIZE_A : PH_SHAPE;
              res_valid = 1'b1;
              res.kind  = thp_pkg::KIND_DIM;
              res.value = asm_new;
            end
          end
          PH_SIZE_A: begin
            if (fbc_eff == 3'd7) begin
              orig_d  = asm_new;
              fbc_d   = 3'd0;
              asm_d   = 64'd0;
              phase_d = PH_SIZE_B;
            end
          end
          PH_SIZE_B: begin
            if (fbc_eff == 3'd7) begin
              phase_d              = PH_IDLE;
              fbc_d                = fbc_eff;
              res_valid            = 1'b1;
              res.kind             = thp_pkg::KIND_DONE;
              res.value            = orig_q;
              res.stored_size      = asm_new;
              res.dtype_code       = dtype_q;
              res.compression_code = comp_q;
              res.dim_count        = dc_q;
              res.name_length      = nl_q;
              res.payload_offset   = pos_new;
              res.last             = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      if (res_valid) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      fbc_q       <= 3'd0;
      len_q       <= '0;
      asm_q       <= 64'd0;
      orig_q      <= 64'd0;
      dtype_q     <= 8'd0;
      comp_q      <= 8'd0;
      dc_q        <= 8'd0;
      nl_q        <= 8'd0;
      items_q     <= 8'd0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      fbc_q       <= fbc_d;
      len_q       <= len_d;
      asm_q       <= asm_d;
      orig_q      <= orig_d;
      dtype_q     <= dtype_d;
      comp_q      <= comp_d;
      dc_q        <= dc_d;
      nl_q        <= nl_d;
      items_q     <= items_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `THP_ASSERT_IMPL(a_name_count, phase_q == PH_NAME, items_q != 8'd0, "name phase with no bytes left")
  `THP_ASSERT_IMPL(a_shape_count, phase_q == PH_SHAPE, items_q != 8'd0, "shape phase with no dims left")
  `THP_ASSERT_IMPL(a_item_not_last, out_valid_q && (out_q.kind == thp_pkg::KIND_NAME || out_q.kind == thp_pkg::KIND_DIM), !out_q.last, "name or dim word flagged last")

endmodule

// ===== src/tensor_header_parser.sv =====
`timescale 1ns / 1ps
`include "tensor_header_parser_defines.svh"
// Tensor header parser. Software writes the expected magic, the expected version and the
// minimum header size through the configuration port while the parser is idle.
// Buffer bytes arrive one word per cycle on the input channel while it is ready; the
// word that starts a buffer has first_byte set and carries the total buffer length.
// The output channel returns one word per name byte and per shape dimension, then a
// final word flagged last: either done, with the header fields and data offset, or an
// error code. Bytes after the final word are dropped until the next first byte.
// Input words pass through a small queue to the parsing engine, which handles one byte
// per cycle unless the output stalls, so the sustained rate is one input word per
// cycle. A result is registered on the output in the cycle after its byte is popped.
// When the receiver stalls, the output register holds its word and the queue absorbs
// incoming words; input ready drops once the queue is full.
// Reset empties the queue and the output register, returns the parser to idle and
// loads the configuration defaults: magic zero, version zero, minimum size 32.

module tensor_header_parser #(
  parameter int LENGTH_BITS = thp_pkg::DefLengthBits,
  parameter int FIFO_DEPTH  = thp_pkg::DefFifoDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [63:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  thp_pkg::thp_in_t            in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output thp_pkg::thp_out_t           out_word_o
);

  localparam int LenW   = (LENGTH_BITS < thp_pkg::InLenW) ? LENGTH_BITS : thp_pkg::InLenW;
  localparam int EntryW = LenW + 10;

  logic [63:0]                 magic_q;
  logic [31:0]                 version_q;
  logic [thp_pkg::OffsetW-1:0] min_size_q;
  logic [EntryW-1:0]           entry_in, entry_out;
  logic                        fifo_full, fifo_valid, fifo_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= 64'd0;
      version_q  <= 32'd0;
      min_size_q <= thp_pkg::DefMinHeaderSize;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        thp_pkg::CFG_MAGIC:    magic_q    <= cfg_wdata_i;
        thp_pkg::CFG_VERSION:  version_q  <= cfg_wdata_i[31:0];
        thp_pkg::CFG_MIN_SIZE: min_size_q <= cfg_wdata_i[thp_pkg::OffsetW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = !fifo_full;

  thp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .in_word_i (in_word_i),
    .min_size_i(min_size_q),
    .entry_o   (entry_in)
  );

  thp_fifo #(
    .WIDTH(EntryW),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_data_i(entry_in),
    .full_o     (fifo_full),
    .pop_i      (fifo_pop),
    .valid_o    (fifo_valid),
    .pop_data_o (entry_out)
  );

  thp_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .magic_i      (magic_q),
    .version_i    (version_q),
    .entry_valid_i(fifo_valid),
    .entry_i      (entry_out),
    .pop_o        (fifo_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

  `THP_ASSERT_IMPL(a_done_clean, out_valid_o && out_word_o.kind == thp_pkg::KIND_DONE, out_word_o.last && out_word_o.error_code == thp_pkg::ERR_TOO_SMALL, "done word malformed")

endmodule

// ===== tb/tensor_header_parser_tb.sv =====
`timescale 1ns / 1ps

module tensor_header_parser_tb;
  import thp_pkg::*;

  localparam int SETTLE       = 10;
  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_WORDS = 750;
  localparam int PHASES       = 6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAGIC, ST_VERSION, ST_FIELDS, ST_NAME, ST_SHAPE, ST_SIZE_A, ST_SIZE_B
  } parse_state_e;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    thp_cfg_e    index;
    logic [63:0] data;
    thp_in_t     word;
    bit          typed;
    bit          has_res;
    thp_out_t    res;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  thp_in_t     in_word_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  thp_out_t    out_word_o;

  tensor_header_parser u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // Parser model state and its copy of the registers.
  logic [63:0]  want_magic;
  logic [31:0]  want_version;
  logic [10:0]  min_size;
  parse_state_e pstate;
  logic [10:0]  byte_pos;
  logic [2:0]   field_cnt;
  logic [31:0]  buf_len;
  logic [63:0]  word_acc;
  logic [63:0]  orig_size;
  logic [7:0]   dtype_q;
  logic [7:0]   comp_q;
  logic [7:0]   ndim_q;
  logic [7:0]   nlen_q;
  logic [7:0]   items_left;

  thp_out_t pending_results[$];
  int       errors       = 0;
  int       idle_cycles  = 0;
  int       words_sent   = 0;
  int       in_gap_pct   = 0;
  int       out_stall_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic thp_out_t error_result(thp_err_e code);
    thp_out_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic void start_field(parse_state_e next);
    pstate    = next;
    field_cnt = '0;
    word_acc  = '0;
  endfunction

  function automatic void reset_parser_model();
    want_magic   = '0;
    want_version = '0;
    min_size     = DefMinHeaderSize;
    pstate       = ST_IDLE;
    byte_pos     = '0;
    field_cnt    = '0;
    buf_len      = '0;
    word_acc     = '0;
    orig_size    = '0;
    dtype_q      = '0;
    comp_q       = '0;
    ndim_q       = '0;
    nlen_q       = '0;
    items_left   = '0;
  endfunction

  // Advances the model by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input thp_in_t w, output thp_out_t r);
    logic [31:0] need;
    logic [63:0] dim;
    r = '0;
    if (w.first_byte) begin
      buf_len    = w.buffer_length;
      byte_pos   = '0;
      items_left = '0;
      if (buf_len < min_size || buf_len < MinLength) begin
        pstate = ST_IDLE;
        r = error_result(ERR_TOO_SMALL);
        return 1'b1;
      end
      start_field(ST_MAGIC);
    end
    if (pstate == ST_IDLE) return 1'b0;
    byte_pos = byte_pos + 11'd1;
    case (pstate)
      ST_MAGIC: begin
        word_acc[8*field_cnt +: 8] = w.byte_value;
        if (field_cnt == 3'd7) begin
          if (word_acc != want_magic) begin
            pstate = ST_IDLE;
            r = error_result(ERR_MAGIC);
            return 1'b1;
          end
          start_field(ST_VERSION);
        end else begin
          field_cnt++;
        end
      end
      ST_VERSION: begin
        word_acc[8*field_cnt +: 8] = w.byte_value;
        if (field_cnt == 3'd3) begin
          pstate = ST_IDLE;
          if (word_acc[31:0] != want_version) begin
            r = error_result(ERR_VERSION);
            return 1'b1;
          end
          if (buf_len < 32'd16) begin
            r = error_result(ERR_FIELDS);
            return 1'b1;
          end
          start_field(ST_FIELDS);
        end else begin
          field_cnt++;
        end
      end
      ST_FIELDS: begin
        case (field_cnt)
          3'd0: dtype_q = w.byte_value;
          3'd1: comp_q  = w.byte_value;
          3'd2: ndim_q  = w.byte_value;
          default: begin
            nlen_q = w.byte_value;
            pstate = ST_IDLE;
            need   = 32'd16 + nlen_q;
            if (need > buf_len) begin
              r = error_result(ERR_NAME);
              return 1'b1;
            end
            need = need + 32'd4 * ndim_q;
            if (need > buf_len) begin
              r = error_result(ERR_SHAPE);
              return 1'b1;
            end
            if (need + 32'd16 > buf_len) begin
              r = error_result(ERR_SIZES);
              return 1'b1;
            end
            if (nlen_q != 0) begin
              pstate     = ST_NAME;
              items_left = nlen_q;
            end else if (ndim_q != 0) begin
              start_field(ST_SHAPE);
              items_left = ndim_q;
            end else begin
              start_field(ST_SIZE_A);
            end
            return 1'b0;
          end
        endcase
        field_cnt++;
      end
      ST_NAME: begin
        items_left = items_left - 8'd1;
        if (items_left == 0) begin
          if (ndim_q != 0) begin
            start_field(ST_SHAPE);
            items_left = ndim_q;
          end else begin
            start_field(ST_SIZE_A);
          end
        end
        r.kind  = KIND_NAME;
        r.value = 64'(w.byte_value);
        return 1'b1;
      end
      ST_SHAPE: begin
        word_acc[8*field_cnt +: 8] = w.byte_value;
        if (field_cnt == 3'd3) begin
          dim        = word_acc;
          items_left = items_left - 8'd1;
          if (items_left == 0) start_field(ST_SIZE_A);
          else start_field(ST_SHAPE);
          r.kind  = KIND_DIM;
          r.value = dim;
          return 1'b1;
        end
        field_cnt++;
      end
      ST_SIZE_A: begin
        word_acc[8*field_cnt +: 8] = w.byte_value;
        if (field_cnt == 3'd7) begin
          orig_size = word_acc;
          start_field(ST_SIZE_B);
        end else begin
          field_cnt++;
        end
      end
      ST_SIZE_B: begin
        word_acc[8*field_cnt +: 8] = w.byte_value;
        if (field_cnt == 3'd7) begin
          r.kind             = KIND_DONE;
          r.value            = orig_size;
          r.stored_size      = word_acc;
          r.dtype_code       = dtype_q;
          r.compression_code = comp_q;
          r.dim_count        = ndim_q;
          r.name_length      = nlen_q;
          r.payload_offset   = byte_pos;
          r.last             = 1'b1;
          pstate = ST_IDLE;
          return 1'b1;
        end
        field_cnt++;
      end
      default: pstate = ST_IDLE;
    endcase
    return 1'b0;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(thp_out_t got);
    thp_out_t want;
    if (pending_results.size() == 0) begin
      $error("result word with nothing pending: kind %0d value %0h", got.kind, got.value);
      errors++;
    end else begin
      want = pending_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("value", want.value, got.value);
      compare_field("stored_size", want.stored_size, got.stored_size);
      compare_field("dtype_code", want.dtype_code, got.dtype_code);
      compare_field("compression_code", want.compression_code, got.compression_code);
      compare_field("dim_count", want.dim_count, got.dim_count);
      compare_field("name_length", want.name_length, got.name_length);
      compare_field("payload_offset", want.payload_offset, got.payload_offset);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (out_valid_o && out_ready_i) check_result(out_word_o);
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) < out_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(thp_cfg_e idx, logic [63:0] data);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAGIC:   want_magic   = data;
      CFG_VERSION: want_version = data[31:0];
      default:     min_size     = data[10:0];
    endcase
  endtask

  task automatic put_word(thp_in_t w, bit typed, bit has_res, thp_out_t res);
    thp_out_t pred;
    bit       got;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    got = parse_byte(w, pred);
    if (typed) begin
      if (has_res) pending_results.push_back(res);
    end else if (got) begin
      pending_results.push_back(pred);
    end
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic stim_row_t word_row(logic [7:0] b, logic [31:0] len, bit fb);
    stim_row_t r;
    r.kind    = ROW_WORD;
    r.index   = CFG_MAGIC;
    r.data    = '0;
    r.word    = {b, len, fb};
    r.typed   = 1'b0;
    r.has_res = 1'b0;
    r.res     = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [7:0] b, logic [31:0] len, bit fb,
                                          bit has_res, thp_err_e code);
    stim_row_t r;
    r         = word_row(b, len, fb);
    r.typed   = 1'b1;
    r.has_res = has_res;
    if (has_res) r.res = error_result(code);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(thp_cfg_e idx, logic [63:0] data);
    stim_row_t r;
    r       = word_row(8'h00, '0, 1'b0);
    r.kind  = ROW_CFG;
    r.index = idx;
    r.data  = data;
    return r;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 15;
      default: return 40;
    endcase
  endfunction

  // Sends one header built from the current registers; whole forbids cutting it short.
  task automatic send_header(bit whole);
    logic [7:0]  hdr[$];
    logic [31:0] len;
    thp_in_t     w;
    int          nlen;
    int          ndim;
    int          need;
    int          base;
    int          take;
    int          k;
    int          sel;
    for (int i = 0; i < 8; i++) hdr.push_back(want_magic[8*i +: 8]);
    for (int i = 0; i < 4; i++) hdr.push_back(want_version[8*i +: 8]);
    if ($urandom_range(0, 5) == 0) begin
      k = $urandom_range(0, 11);
      hdr[k] = hdr[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    sel  = $urandom_range(0, 99);
    nlen = (sel < 80) ? $urandom_range(0, 8) : (sel < 96) ? $urandom_range(0, 40)
                                                          : $urandom_range(0, 255);
    sel  = $urandom_range(0, 99);
    ndim = (sel < 80) ? $urandom_range(0, 4) : (sel < 96) ? $urandom_range(0, 20)
                                                          : $urandom_range(0, 255);
    hdr.push_back(8'($urandom));
    hdr.push_back(8'($urandom));
    hdr.push_back(8'(ndim));
    hdr.push_back(8'(nlen));
    for (int i = 0; i < nlen + 4 * ndim + 16; i++) hdr.push_back(8'($urandom));
    need = 32 + nlen + 4 * ndim;
    base = (need > min_size) ? need : int'(min_size);
    sel  = $urandom_range(0, 99);
    if (sel < 55) len = 32'(base + $urandom_range(0, 3));
    else if (sel < 65) len = $urandom;
    else if (sel < 82) len = 32'($urandom_range(12, need - 1));
    else if (sel < 92) len = 32'($urandom_range(0, 15));
    else len = 32'hFFFF_FFFF;
    if (!whole && $urandom_range(0, 19) == 0) begin
      w = {8'($urandom), 32'($urandom), 1'b1};
      put_word(w, 1'b0, 1'b0, '0);
    end
    take = hdr.size();
    if (!whole && $urandom_range(0, 99) < 12) take = $urandom_range(1, hdr.size() - 1);
    for (int i = 0; i < take; i++) begin
      w.byte_value    = hdr[i];
      w.first_byte    = (i == 0);
      w.buffer_length = (i == 0) ? len : 32'($urandom);
      put_word(w, 1'b0, 1'b0, '0);
    end
    words_sent += take;
    if (take == hdr.size() && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        w = {8'($urandom), 32'($urandom), 1'b0};
        put_word(w, 1'b0, 1'b0, '0);
      end
    end
  endtask

  initial begin
    stim_row_t directed_rows[$];
    reset_parser_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Idle bytes, both too-small cases, a header restarted midway, a bad magic,
    // a byte ignored after the error, and a minimum size of 1307.
    directed_rows.push_back(typed_row(8'hA5, 32'd0, 1'b0, 1'b0, ERR_TOO_SMALL));
    directed_rows.push_back(typed_row(8'h00, 32'd31, 1'b1, 1'b1, ERR_TOO_SMALL));
    directed_rows.push_back(cfg_row(CFG_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(cfg_row(CFG_MIN_SIZE, 64'd0));
    directed_rows.push_back(typed_row(8'h00, 32'd0, 1'b1, 1'b1, ERR_TOO_SMALL));
    directed_rows.push_back(typed_row(8'hFF, 32'd11, 1'b1, 1'b1, ERR_TOO_SMALL));
    directed_rows.push_back(word_row(8'hFF, 32'hFFFF_FFFF, 1'b1));
    repeat (6) directed_rows.push_back(word_row(8'hFF, 32'd0, 1'b0));
    directed_rows.push_back(word_row(8'hFF, 32'd12, 1'b1));
    repeat (6) directed_rows.push_back(word_row(8'hFF, 32'hFFFF_FFFF, 1'b0));
    directed_rows.push_back(typed_row(8'h7F, 32'd0, 1'b0, 1'b1, ERR_MAGIC));
    directed_rows.push_back(typed_row(8'h55, 32'd0, 1'b0, 1'b0, ERR_TOO_SMALL));
    directed_rows.push_back(cfg_row(CFG_MIN_SIZE, 64'd1307));
    directed_rows.push_back(typed_row(8'hFF, 32'd1306, 1'b1, 1'b1, ERR_TOO_SMALL));

    in_gap_pct    = 15;
    out_stall_pct = 15;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        put_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].has_res,
                 directed_rows[i].res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_MAGIC, 64'd0);
          write_reg(CFG_VERSION, 64'd0);
          write_reg(CFG_MIN_SIZE, 64'd0);
        end
        1: begin
          write_reg(CFG_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(CFG_VERSION, 64'hFFFF_FFFF);
          write_reg(CFG_MIN_SIZE, 64'd1307);
        end
        default: begin
          write_reg(CFG_MAGIC, {$urandom, $urandom});
          write_reg(CFG_VERSION, 64'($urandom));
          write_reg(CFG_MIN_SIZE, 64'($urandom_range(0, 40)));
        end
      endcase
      in_gap_pct    = (p == PHASES - 1) ? 0 : pick_pct();
      out_stall_pct = (p == PHASES - 1) ? 0 : pick_pct();
      while (words_sent < (p + 1) * RANDOM_WORDS / PHASES) send_header(1'b0);
      send_header(1'b1);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
